### hw/rtl/rcgf_pkg.sv
// Package for the ring colour gradient fill: controller states and fixed field widths.
package rcgf_pkg;

  localparam int unsigned PosW    = 7;
  localparam int unsigned IdxW    = 6;
  localparam int unsigned ColW    = 8;
  localparam int unsigned DivW    = 6;   // span divisor, 1..63
  localparam int unsigned QuoW    = 15;  // |diff| << 7
  localparam int unsigned AccW    = 16;  // 8.8 accumulator, only bits [15:8] are shown
  localparam int unsigned StepW   = 4;
  localparam int unsigned NumChan = 3;

  localparam logic [StepW-1:0] LastStep = StepW'(QuoW - 1);

  typedef enum logic [2:0] {
    StIdle,
    StCheck,
    StDivide,
    StEmit,
    StReject
  } state_e;

  typedef enum logic [1:0] {
    ChRed,
    ChGreen,
    ChBlue
  } chan_e;

endpackage

### hw/rtl/ring_color_gradient_fill.sv
// Ring colour gradient fill: one command in, one result per pixel out.
//
// Input channel (in_valid_i / in_stall_o) takes one command: start and end
// positions and start and end RGB colours. A transaction completes when valid
// is high and stall is low. Only one command is held at a time; the input
// stalls from acceptance until the last result has been loaded into the
// output register.
// Output channel (out_valid_o / out_stall_i) carries one pixel per transaction:
// wrapped index, colour and a last mark. A refused command gives a single
// result with rejected and last set and zero colour/index.
// After the range check state, restoring division computes each channel's slope
// in turn (one quotient bit per cycle, one divider shared by the channels).
// Pixels then follow one per cycle while the output is not stalled; a refused
// command goes from the check state to the reject state, skipping division.
// A stalled result is held; the pixel sequencer waits until it is taken.
// The user writes the strip length register (cfg_valid_i / cfg_ready_o) only while idle; the block does not enforce it.
// Reset clears the controller and output valid and sets the strip length to 64.
module ring_color_gradient_fill #(
  parameter int unsigned MAX_PIXELS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,

  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [6:0] cfg_strip_length_i,

  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [6:0] start_pos_i,
  input  logic [6:0] end_pos_i,
  input  logic [7:0] start_red_i,
  input  logic [7:0] start_green_i,
  input  logic [7:0] start_blue_i,
  input  logic [7:0] end_red_i,
  input  logic [7:0] end_green_i,
  input  logic [7:0] end_blue_i,

  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [5:0] pixel_index_o,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o,
  output logic       last_o,
  output logic       rejected_o
);

  localparam int unsigned PosW  = rcgf_pkg::PosW;
  localparam int unsigned IdxW  = rcgf_pkg::IdxW;
  localparam int unsigned ColW  = rcgf_pkg::ColW;
  localparam int unsigned DivW  = rcgf_pkg::DivW;
  localparam int unsigned QuoW  = rcgf_pkg::QuoW;
  localparam int unsigned AccW  = rcgf_pkg::AccW;
  localparam int unsigned StepW = rcgf_pkg::StepW;

  localparam logic [PosW-1:0] MaxLen = PosW'(MAX_PIXELS);
  localparam logic [PosW-1:0] MinLen = PosW'(2);

  // Magnitude of (end - start) << 7 and its sign.
  function automatic logic [QuoW:0] dividend_of(logic [ColW-1:0] s, logic [ColW-1:0] e);
    logic [ColW-1:0] mag;
    logic            neg;
    neg = (e < s);
    mag = neg ? (s - e) : (e - s);
    return {neg, mag, 7'b0};
  endfunction

  rcgf_pkg::state_e state_q, state_d;

  logic [PosW-1:0] strip_len_q;
  logic [PosW-1:0] len_q;
  logic [PosW-1:0] sp_q, ep_q;
  logic [ColW-1:0] sr_q, sg_q, sb_q, er_q, eg_q, eb_q;

  logic [DivW-1:0]  div_q;
  logic [DivW-1:0]  rem_q, rem_d;
  logic [QuoW-1:0]  dq_q, dq_d;
  logic             neg_q;
  logic [StepW-1:0] step_q;
  rcgf_pkg::chan_e  ch_q;

  logic [AccW-1:0] slope_r_q, slope_g_q, slope_b_q;
  logic [AccW-1:0] acc_r_q, acc_g_q, acc_b_q;
  logic [IdxW-1:0] idx_q;
  logic [PosW-1:0] remain_q;

  logic            out_valid_q;
  logic [IdxW-1:0] out_idx_q;
  logic [ColW-1:0] out_r_q, out_g_q, out_b_q;
  logic            out_last_q, out_rej_q;

  // Range checks on the captured command
  logic [PosW-1:0] len_eff;
  logic [PosW:0]   len2;
  logic [PosW-1:0] span;
  logic            reject;
  logic [PosW-1:0] sp_w, ep_w;
  logic [PosW-1:0] count;

  always_comb begin
    len_eff = strip_len_q;
    if (strip_len_q < MinLen) begin
      len_eff = MinLen;
    end else if (strip_len_q > MaxLen) begin
      len_eff = MaxLen;
    end
    len2   = {len_eff, 1'b0};
    span   = ep_q - sp_q;
    reject = (ep_q < sp_q) || (span >= len_eff) ||
             ({1'b0, sp_q} >= len2) || ({1'b0, ep_q} >= len2);
    sp_w   = (sp_q >= len_eff) ? (sp_q - len_eff) : sp_q;
    ep_w   = (ep_q >= len_eff) ? (ep_q - len_eff) : ep_q;
    count  = (ep_w < sp_w) ? span : (span + PosW'(1));
  end

  // One restoring division step per cycle
  logic [DivW:0]   trial;
  logic            qbit;
  logic [AccW-1:0] slope_new;

  always_comb begin
    trial = {rem_q, dq_q[QuoW-1]};
    qbit  = (trial >= {1'b0, div_q});
    rem_d = qbit ? DivW'(trial - {1'b0, div_q}) : trial[DivW-1:0];
    dq_d  = {dq_q[QuoW-2:0], qbit};
    slope_new = neg_q ? (AccW'(0) - {dq_d, 1'b0}) : {dq_d, 1'b0};
  end

  // Dividend for the channel that follows the current one
  logic [QuoW:0] next_dividend;

  always_comb begin
    case (ch_q)
      rcgf_pkg::ChRed:   next_dividend = dividend_of(sg_q, eg_q);
      rcgf_pkg::ChGreen: next_dividend = dividend_of(sb_q, eb_q);
      default:           next_dividend = dividend_of(sr_q, er_q);
    endcase
  end

  logic slot_free;
  assign slot_free = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rcgf_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = rcgf_pkg::StCheck;
        end
      end
      rcgf_pkg::StCheck: begin
        state_d = reject ? rcgf_pkg::StReject : rcgf_pkg::StDivide;
      end
      rcgf_pkg::StDivide: begin
        if (step_q == rcgf_pkg::LastStep && ch_q == rcgf_pkg::ChBlue) begin
          state_d = rcgf_pkg::StEmit;
        end
      end
      rcgf_pkg::StEmit: begin
        if (slot_free && remain_q == PosW'(1)) begin
          state_d = rcgf_pkg::StIdle;
        end
      end
      rcgf_pkg::StReject: begin
        if (slot_free) begin
          state_d = rcgf_pkg::StIdle;
        end
      end
      default: state_d = rcgf_pkg::StIdle;
    endcase
  end

  // Control outputs
  logic accept, start_div, div_step, load_pixel, load_reject;

  always_comb begin
    in_stall_o  = 1'b1;
    start_div   = 1'b0;
    div_step    = 1'b0;
    load_pixel  = 1'b0;
    load_reject = 1'b0;
    case (state_q)
      rcgf_pkg::StIdle:   in_stall_o  = 1'b0;
      rcgf_pkg::StCheck:  start_div   = !reject;
      rcgf_pkg::StDivide: div_step    = 1'b1;
      rcgf_pkg::StEmit:   load_pixel  = slot_free;
      rcgf_pkg::StReject: load_reject = slot_free;
      default:            in_stall_o  = 1'b1;
    endcase
  end

  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rcgf_pkg::StIdle;
      strip_len_q <= PosW'(64);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        strip_len_q <= cfg_strip_length_i;
      end
      if (load_pixel || load_reject) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  logic [PosW-1:0] idx_inc;
  assign idx_inc = {1'b0, idx_q} + PosW'(1);

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sp_q <= start_pos_i;
      ep_q <= end_pos_i;
      sr_q <= start_red_i;
      sg_q <= start_green_i;
      sb_q <= start_blue_i;
      er_q <= end_red_i;
      eg_q <= end_green_i;
      eb_q <= end_blue_i;
    end

    if (start_div) begin
      len_q    <= len_eff;
      div_q    <= (span == '0) ? DivW'(1) : span[DivW-1:0];
      idx_q    <= sp_w[IdxW-1:0];
      remain_q <= count;
      acc_r_q  <= {sr_q, 8'b0};
      acc_g_q  <= {sg_q, 8'b0};
      acc_b_q  <= {sb_q, 8'b0};
      {neg_q, dq_q} <= dividend_of(sr_q, er_q);
      rem_q    <= '0;
      step_q   <= '0;
      ch_q     <= rcgf_pkg::ChRed;
    end else if (div_step) begin
      if (step_q == rcgf_pkg::LastStep) begin
        case (ch_q)
          rcgf_pkg::ChRed:   slope_r_q <= slope_new;
          rcgf_pkg::ChGreen: slope_g_q <= slope_new;
          default:           slope_b_q <= slope_new;
        endcase
        {neg_q, dq_q} <= next_dividend;
        rem_q  <= '0;
        step_q <= '0;
        case (ch_q)
          rcgf_pkg::ChRed:   ch_q <= rcgf_pkg::ChGreen;
          rcgf_pkg::ChGreen: ch_q <= rcgf_pkg::ChBlue;
          default:           ch_q <= rcgf_pkg::ChRed;
        endcase
      end else begin
        rem_q  <= rem_d;
        dq_q   <= dq_d;
        step_q <= step_q + StepW'(1);
      end
    end

    if (load_pixel) begin
      out_idx_q  <= idx_q;
      out_r_q    <= acc_r_q[AccW-1:8];
      out_g_q    <= acc_g_q[AccW-1:8];
      out_b_q    <= acc_b_q[AccW-1:8];
      out_last_q <= (remain_q == PosW'(1));
      out_rej_q  <= 1'b0;
      acc_r_q    <= acc_r_q + slope_r_q;
      acc_g_q    <= acc_g_q + slope_g_q;
      acc_b_q    <= acc_b_q + slope_b_q;
      idx_q      <= (idx_inc >= len_q) ? '0 : idx_inc[IdxW-1:0];
      remain_q   <= remain_q - PosW'(1);
    end else if (load_reject) begin
      out_idx_q  <= '0;
      out_r_q    <= '0;
      out_g_q    <= '0;
      out_b_q    <= '0;
      out_last_q <= 1'b1;
      out_rej_q  <= 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_index_o = out_idx_q;
  assign red_o         = out_r_q;
  assign green_o       = out_g_q;
  assign blue_o        = out_b_q;
  assign last_o        = out_last_q;
  assign rejected_o    = out_rej_q;

endmodule

### tb/ring_color_gradient_fill_checker.sv
// Checker for the ring colour gradient fill: watches all channels, predicts pixels, compares.
module ring_color_gradient_fill_checker #(
  parameter int unsigned MaxPixels = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,

  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [rcgf_pkg::PosW-1:0] cfg_strip_length_i,

  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic [rcgf_pkg::PosW-1:0] start_pos_i,
  input  logic [rcgf_pkg::PosW-1:0] end_pos_i,
  input  logic [rcgf_pkg::ColW-1:0] start_red_i,
  input  logic [rcgf_pkg::ColW-1:0] start_green_i,
  input  logic [rcgf_pkg::ColW-1:0] start_blue_i,
  input  logic [rcgf_pkg::ColW-1:0] end_red_i,
  input  logic [rcgf_pkg::ColW-1:0] end_green_i,
  input  logic [rcgf_pkg::ColW-1:0] end_blue_i,

  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic [rcgf_pkg::IdxW-1:0] pixel_index_i,
  input  logic [rcgf_pkg::ColW-1:0] red_i,
  input  logic [rcgf_pkg::ColW-1:0] green_i,
  input  logic [rcgf_pkg::ColW-1:0] blue_i,
  input  logic                      last_i,
  input  logic                      rejected_i,

  output int                        fail_count_o,
  output int                        pending_o,
  output int                        cmd_count_o,
  output int                        pixel_count_o,
  output int                        refused_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PosW = rcgf_pkg::PosW;
  localparam int unsigned IdxW = rcgf_pkg::IdxW;
  localparam int unsigned ColW = rcgf_pkg::ColW;

  typedef struct packed {
    logic [IdxW-1:0] index;
    logic [ColW-1:0] red;
    logic [ColW-1:0] green;
    logic [ColW-1:0] blue;
    logic            last;
    logic            rejected;
  } pixel_t;

  pixel_t          expected_pixels_q[$];
  pixel_t          oldest_px;
  logic [PosW-1:0] strip_len;
  int              fails;
  int              cmds;
  int              pixels;
  int              refused;

  // 8.8 step per pixel; integer division truncates toward zero
  function automatic int slope_8p8(input logic [ColW-1:0] from, input logic [ColW-1:0] to,
                                   input int div);
    int a;
    int b;
    a = from;
    b = to;
    return ((b - a) * 128 / div) * 2;
  endfunction

  function automatic void plan_gradient(input logic [PosW-1:0] sp_in,
                                        input logic [PosW-1:0] ep_in,
                                        input logic [ColW-1:0] sr, input logic [ColW-1:0] sg,
                                        input logic [ColW-1:0] sb, input logic [ColW-1:0] er,
                                        input logic [ColW-1:0] eg, input logic [ColW-1:0] eb);
    int unsigned eff;
    int unsigned sp;
    int unsigned ep;
    int unsigned span;
    int unsigned count;
    int unsigned pos;
    int          div;
    int          step_r;
    int          step_g;
    int          step_b;
    int          acc_r;
    int          acc_g;
    int          acc_b;
    pixel_t      px;
    eff = strip_len;
    if (eff < 2) eff = 2;
    if (eff > MaxPixels) eff = MaxPixels;
    sp = sp_in;
    ep = ep_in;
    px = '0;
    // backwards, too long, or more than one lap out: single refused result
    if (ep < sp || ep - sp >= eff || sp >= 2 * eff || ep >= 2 * eff) begin
      px.last     = 1'b1;
      px.rejected = 1'b1;
      expected_pixels_q.push_back(px);
      refused++;
      return;
    end
    span   = ep - sp;
    div    = (span == 0) ? 1 : int'(span);
    step_r = slope_8p8(sr, er, div);
    step_g = slope_8p8(sg, eg, div);
    step_b = slope_8p8(sb, eb, div);
    acc_r  = {16'd0, sr, 8'd0};
    acc_g  = {16'd0, sg, 8'd0};
    acc_b  = {16'd0, sb, 8'd0};
    if (sp >= eff) sp -= eff;
    if (ep >= eff) ep -= eff;
    // across the wrap point the end pixel itself is not drawn
    count = (ep < sp) ? span : ep - sp + 1;
    if (count > MaxPixels) count = MaxPixels;
    pos = sp;
    for (int unsigned k = 0; k < count; k++) begin
      px.index    = pos[IdxW-1:0];
      px.red      = acc_r[15:8];
      px.green    = acc_g[15:8];
      px.blue     = acc_b[15:8];
      px.last     = (k + 1 == count);
      px.rejected = 1'b0;
      expected_pixels_q.push_back(px);
      acc_r += step_r;
      acc_g += step_g;
      acc_b += step_b;
      pos++;
      if (pos >= eff) pos = 0;
    end
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      fails++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_len = 7'd64;
      expected_pixels_q.delete();
      fails   = 0;
      cmds    = 0;
      pixels  = 0;
      refused = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) strip_len = cfg_strip_length_i;
      if (in_valid_i && !in_stall_i) begin
        cmds++;
        plan_gradient(start_pos_i, end_pos_i, start_red_i, start_green_i, start_blue_i,
                      end_red_i, end_green_i, end_blue_i);
      end
      if (out_valid_i && !out_stall_i) begin
        pixels++;
        if (expected_pixels_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected pixel transaction, expected none, actual index %0d",
                   $time, pixel_index_i);
        end else begin
          oldest_px = expected_pixels_q.pop_front();
          check_field("pixel_index", oldest_px.index, pixel_index_i);
          check_field("red", oldest_px.red, red_i);
          check_field("green", oldest_px.green, green_i);
          check_field("blue", oldest_px.blue, blue_i);
          check_field("last", oldest_px.last, last_i);
          check_field("rejected", oldest_px.rejected, rejected_i);
        end
      end
    end
    fail_count_o    <= fails;
    pending_o       <= expected_pixels_q.size();
    cmd_count_o     <= cmds;
    pixel_count_o   <= pixels;
    refused_count_o <= refused;
  end

endmodule

### tb/ring_color_gradient_fill_tb.sv
// Testbench top for the ring colour gradient fill: clock, reset, stimulus and verdict.
module ring_color_gradient_fill_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PosW          = rcgf_pkg::PosW;
  localparam int unsigned IdxW          = rcgf_pkg::IdxW;
  localparam int unsigned ColW          = rcgf_pkg::ColW;
  localparam int unsigned MaxPixels     = 64;
  localparam int unsigned QuietLimit    = 2000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned IdlePct       = 15;
  localparam int unsigned RandPerPhase  = 30;
  localparam int unsigned TailCycles    = 120;

  logic            clk;
  logic            rst_n;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [PosW-1:0] cfg_len;
  logic            in_valid;
  logic            in_stall;
  logic [PosW-1:0] start_pos;
  logic [PosW-1:0] end_pos;
  logic [ColW-1:0] start_red;
  logic [ColW-1:0] start_green;
  logic [ColW-1:0] start_blue;
  logic [ColW-1:0] end_red;
  logic [ColW-1:0] end_green;
  logic [ColW-1:0] end_blue;
  logic            out_valid;
  logic            out_stall;
  logic [IdxW-1:0] pixel_index;
  logic [ColW-1:0] red;
  logic [ColW-1:0] green;
  logic [ColW-1:0] blue;
  logic            last;
  logic            rejected;

  int          fail_count;
  int          pending;
  int          cmd_count;
  int          pixel_count;
  int          refused_count;
  bit          calm;
  bit          squeeze_req;
  int unsigned settings_used;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  ring_color_gradient_fill #(
    .MAX_PIXELS(MaxPixels)
  ) u_top (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_strip_length_i(cfg_len),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .start_pos_i       (start_pos),
    .end_pos_i         (end_pos),
    .start_red_i       (start_red),
    .start_green_i     (start_green),
    .start_blue_i      (start_blue),
    .end_red_i         (end_red),
    .end_green_i       (end_green),
    .end_blue_i        (end_blue),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .pixel_index_o     (pixel_index),
    .red_o             (red),
    .green_o           (green),
    .blue_o            (blue),
    .last_o            (last),
    .rejected_o        (rejected)
  );

  ring_color_gradient_fill_checker #(
    .MaxPixels(MaxPixels)
  ) u_chk (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_strip_length_i(cfg_len),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .start_pos_i       (start_pos),
    .end_pos_i         (end_pos),
    .start_red_i       (start_red),
    .start_green_i     (start_green),
    .start_blue_i      (start_blue),
    .end_red_i         (end_red),
    .end_green_i       (end_green),
    .end_blue_i        (end_blue),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .pixel_index_i     (pixel_index),
    .red_i             (red),
    .green_i           (green),
    .blue_i            (blue),
    .last_i            (last),
    .rejected_i        (rejected),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .cmd_count_o       (cmd_count),
    .pixel_count_o     (pixel_count),
    .refused_count_o   (refused_count)
  );

  function automatic logic [ColW-1:0] pick_colour();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return ColW'($urandom_range(255));
    endcase
  endfunction

  task automatic send_cmd(input logic [PosW-1:0] sp, input logic [PosW-1:0] ep,
                          input logic [ColW-1:0] sr, input logic [ColW-1:0] sg,
                          input logic [ColW-1:0] sb, input logic [ColW-1:0] er,
                          input logic [ColW-1:0] eg, input logic [ColW-1:0] eb);
    while (!calm && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    start_pos   <= sp;
    end_pos     <= ep;
    start_red   <= sr;
    start_green <= sg;
    start_blue  <= sb;
    end_red     <= er;
    end_green   <= eg;
    end_blue    <= eb;
    do @(posedge clk); while (in_stall);
  endtask

  // mostly legal spans within one lap, some noise and some just one pixel too long
  task automatic send_random(input int unsigned eff);
    int unsigned sp;
    int unsigned ep;
    int unsigned room;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) begin
      sp = $urandom_range(127);
      ep = $urandom_range(127);
    end else if (roll < 18) begin
      sp = $urandom_range(2 * eff - 1);
      ep = (sp + eff > 127) ? 127 : sp + eff;
    end else begin
      sp   = $urandom_range(2 * eff - 1);
      room = 2 * eff - 1 - sp;
      if (room > eff - 1) room = eff - 1;
      ep = sp + $urandom_range(room);
    end
    send_cmd(sp[PosW-1:0], ep[PosW-1:0], pick_colour(), pick_colour(), pick_colour(),
             pick_colour(), pick_colour(), pick_colour());
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_strip_len(input logic [PosW-1:0] len);
    cfg_valid <= 1'b1;
    cfg_len   <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // receiver: random stalls, or one long hold-off when asked
  initial begin : drain
    bit squeezed;
    squeezed = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_req && !squeezed) begin
        squeezed = 1'b1;
        out_stall <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < IdlePct);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no transaction for %0d cycles", $time, QuietLimit);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [PosW-1:0] next_len;
    int unsigned     eff;
    cfg_valid     <= 1'b0;
    cfg_len       <= '0;
    in_valid      <= 1'b0;
    start_pos     <= '0;
    end_pos       <= '0;
    start_red     <= '0;
    start_green   <= '0;
    start_blue    <= '0;
    end_red       <= '0;
    end_green     <= '0;
    end_blue      <= '0;
    rst_n         <= 1'b0;
    calm          = 1'b0;
    squeeze_req   = 1'b0;
    settings_used = 1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset length of 64
    send_cmd(7'd0, 7'd63, 8'd0, 8'd255, 8'd128, 8'd255, 8'd0, 8'd128);
    send_cmd(7'd0, 7'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
    send_cmd(7'd127, 7'd127, 8'd17, 8'd34, 8'd51, 8'd200, 8'd100, 8'd50);
    send_cmd(7'd10, 7'd5, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6);
    send_cmd(7'd0, 7'd64, 8'd9, 8'd9, 8'd9, 8'd90, 8'd90, 8'd90);
    send_cmd(7'd64, 7'd127, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0);
    send_cmd(7'd60, 7'd70, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
    send_cmd(7'd63, 7'd64, 8'd255, 8'd128, 8'd1, 8'd1, 8'd128, 8'd255);
    send_cmd(7'd1, 7'd63, 8'd1, 8'd254, 8'd7, 8'd254, 8'd1, 8'd200);
    send_cmd(7'd127, 7'd0, 8'd170, 8'd85, 8'd170, 8'd85, 8'd170, 8'd85);
    send_cmd(7'd100, 7'd110, 8'd85, 8'd170, 8'd85, 8'd170, 8'd85, 8'd170);
    wait_drained();

    // shortest ring
    write_strip_len(7'd2);
    send_cmd(7'd0, 7'd1, 8'd0, 8'd255, 8'd10, 8'd255, 8'd0, 8'd20);
    send_cmd(7'd1, 7'd2, 8'd100, 8'd100, 8'd100, 8'd0, 8'd200, 8'd100);
    send_cmd(7'd2, 7'd3, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255);
    send_cmd(7'd3, 7'd3, 8'd12, 8'd34, 8'd56, 8'd78, 8'd90, 8'd12);
    send_cmd(7'd4, 7'd4, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
    send_cmd(7'd0, 7'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2);
    wait_drained();

    // below the legal range, treated as two
    write_strip_len(7'd0);
    send_cmd(7'd0, 7'd1, 8'd255, 8'd0, 8'd77, 8'd0, 8'd255, 8'd33);
    send_cmd(7'd2, 7'd3, 8'd40, 8'd80, 8'd120, 8'd160, 8'd200, 8'd240);
    send_cmd(7'd1, 7'd1, 8'd99, 8'd98, 8'd97, 8'd3, 8'd2, 8'd1);
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: next_len = 7'd64;
        1: next_len = PosW'($urandom_range(3, 63));
        2: next_len = 7'd127;
        3: next_len = 7'd1;
        default: next_len = PosW'($urandom_range(2, 64));
      endcase
      write_strip_len(next_len);
      eff = (next_len < 2) ? 2 : ((next_len > MaxPixels) ? MaxPixels : next_len);
      calm        = (ph == 0);
      squeeze_req = (ph == 1);
      repeat (RandPerPhase) send_random(eff);
      wait_drained();
    end
    calm = 1'b0;

    repeat (TailCycles) @(posedge clk);
    $display("Ran %0d gradient commands (%0d refused) over %0d strip length settings,",
             cmd_count, refused_count, settings_used);
    $display("%0d pixels compared, with a %0d-cycle output hold-off and a phase with no idling.",
             pixel_count, HoldOffCycles);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/rcgf_pkg.sv
hw/rtl/ring_color_gradient_fill.sv
tb/ring_color_gradient_fill_checker.sv
tb/ring_color_gradient_fill_tb.sv
